/* rtl/core/tbm_pkg.sv */
// tbm_pkg: shared types, codes, limits and saturating helpers for the
// trackball motion-to-report block. No dependencies.
`default_nettype none

package tbm_pkg;

    typedef enum logic [1:0] {
        REQ_LOCAL  = 2'd0,
        REQ_REMOTE = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    localparam logic CFG_LOCAL_PRESENT = 1'b0;
    localparam logic CFG_DIVIDER       = 1'b1;

    localparam logic [2:0]        DIV_RESET = 3'd4;
    localparam logic signed [15:0] ACC_MAX  = 16'sh7fff;
    localparam logic signed [15:0] ACC_MIN  = 16'sh8000;
    localparam logic signed [7:0]  OUT_LIM  = 8'sd127;

    // per-ball control for one word
    typedef struct packed {
        logic       add_en;
        logic       report_en;
        logic       scroll;
        logic [2:0] shift;
    } t_ball_ctl;

    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] s;
        s = $signed({a[15], a}) + $signed({b[15], b});
        if (s[16] != s[15]) begin
            return s[16] ? ACC_MIN : ACC_MAX;
        end
        return s[15:0];
    endfunction

    function automatic logic signed [7:0] clip8(input logic signed [15:0] v);
        if (v > 16'sd127) begin
            return OUT_LIM;
        end
        if (v < -16'sd127) begin
            return -OUT_LIM;
        end
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/trackball_motion_to_report.sv */
// A report word reaches the master side after it is accepted, through the
// input register and then the result register. Throughput: one word per
// cycle; a held result only stalls the input when a further report is due.
// Reset (i_rst_n low, synchronous) clears both accumulator pairs, empties
// both stages, and sets local ball present to 0 and the divider to 4.
// Depends on tbm_pkg and tbm_ball.
`default_nettype none

module trackball_motion_to_report
    import tbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // motion and report request words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // delta_x[15:0], delta_y[31:16],
                                              // scroll_request[32], zero pad
    input  wire logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    // report words
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // move_x[7:0], move_y[15:8],
                                              // scroll_h[23:16], scroll_v[31:24]
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    logic               r_local_present;
    logic [2:0]         r_div;

    logic               r_in_valid;
    t_req               r_in_req;
    logic signed [15:0] r_in_dx;
    logic signed [15:0] r_in_dy;
    logic               r_in_scroll;

    logic signed [15:0] r_loc_x, r_loc_y, r_rem_x, r_rem_y;
    logic signed [15:0] n_loc_x, n_loc_y, n_rem_x, n_rem_y;

    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic [31:0]        n_out_data;

    logic               is_report;
    logic               fire;
    logic [2:0]         div_eff;
    logic [2:0]         shift;
    t_ball_ctl          loc_ctl;
    t_ball_ctl          rem_ctl;
    logic signed [7:0]  loc_fx, loc_fy, rem_fx, rem_fy;
    logic signed [7:0]  move_x, move_y, scroll_h, scroll_v;

    assign o_cfg_ready = 1'b1;

    assign is_report = (r_in_req == REQ_REPORT);
    assign fire      = r_in_valid && (!is_report || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    // divider zero behaves as the reset value
    assign div_eff = (r_div == 3'd0) ? DIV_RESET : r_div;
    assign shift   = div_eff - 3'd1;

    always_comb begin
        loc_ctl.add_en    = fire && (r_in_req == REQ_LOCAL) && r_local_present;
        loc_ctl.report_en = fire && is_report;
        loc_ctl.scroll    = r_in_scroll;
        loc_ctl.shift     = shift;
        rem_ctl.add_en    = fire && (r_in_req == REQ_REMOTE);
        rem_ctl.report_en = fire && is_report;
        rem_ctl.scroll    = r_in_scroll ^ r_local_present;
        rem_ctl.shift     = shift;
    end

    tbm_ball u_local (
        .i_acc_x (r_loc_x),
        .i_acc_y (r_loc_y),
        .i_dx    (r_in_dx),
        .i_dy    (r_in_dy),
        .i_ctl   (loc_ctl),
        .o_acc_x (n_loc_x),
        .o_acc_y (n_loc_y),
        .o_fx    (loc_fx),
        .o_fy    (loc_fy)
    );

    tbm_ball u_remote (
        .i_acc_x (r_rem_x),
        .i_acc_y (r_rem_y),
        .i_dx    (r_in_dx),
        .i_dy    (r_in_dy),
        .i_ctl   (rem_ctl),
        .o_acc_x (n_rem_x),
        .o_acc_y (n_rem_y),
        .o_fx    (rem_fx),
        .o_fy    (rem_fy)
    );

    // remote ball wins where both write a field
    always_comb begin
        move_x   = 8'sd0;
        move_y   = 8'sd0;
        scroll_h = 8'sd0;
        scroll_v = 8'sd0;
        if (loc_ctl.scroll) begin
            scroll_h = loc_fx;
            scroll_v = loc_fy;
        end else begin
            move_x = loc_fx;
            move_y = loc_fy;
        end
        if (rem_ctl.scroll) begin
            scroll_h = rem_fx;
            scroll_v = rem_fy;
        end else begin
            move_x = rem_fx;
            move_y = rem_fy;
        end
        n_out_data = {scroll_v, scroll_h, move_y, move_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_present <= 1'b0;
            r_div           <= DIV_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCAL_PRESENT: r_local_present <= i_cfg_data[0];
                CFG_DIVIDER:       r_div           <= i_cfg_data;
                default:           r_div           <= r_div;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_req    <= t_req'(i_s_axis_tuser);
            r_in_dx     <= $signed(i_s_axis_tdata[15:0]);
            r_in_dy     <= $signed(i_s_axis_tdata[31:16]);
            r_in_scroll <= i_s_axis_tdata[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_x <= '0;
            r_loc_y <= '0;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else begin
            r_loc_x <= n_loc_x;
            r_loc_y <= n_loc_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_report) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_report) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* rtl/core/tbm_ball.sv */
// tbm_ball: next-state and report fields of one ball's x/y accumulator pair.
// Depends on tbm_pkg.
`default_nettype none

module tbm_ball
    import tbm_pkg::*;
(
    input  wire logic signed [15:0] i_acc_x,
    input  wire logic signed [15:0] i_acc_y,
    input  wire logic signed [15:0] i_dx,
    input  wire logic signed [15:0] i_dy,
    input  wire t_ball_ctl          i_ctl,
    output logic signed [15:0]      o_acc_x,
    output logic signed [15:0]      o_acc_y,
    output logic signed [7:0]       o_fx,
    output logic signed [7:0]       o_fy
);

    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic [15:0]        rem_mask;

    // arithmetic shift gives floor division
    assign q_x      = i_acc_x >>> i_ctl.shift;
    assign q_y      = i_acc_y >>> i_ctl.shift;
    assign rem_mask = ~(16'hffff << i_ctl.shift);

    always_comb begin
        o_acc_x = i_acc_x;
        o_acc_y = i_acc_y;
        if (i_ctl.add_en) begin
            o_acc_x = sat_add16(i_acc_x, i_dx);
            o_acc_y = sat_add16(i_acc_y, i_dy);
        end else if (i_ctl.report_en) begin
            if (i_ctl.scroll) begin
                o_acc_x = $signed(i_acc_x & rem_mask);
                o_acc_y = $signed(i_acc_y & rem_mask);
            end else begin
                o_acc_x = '0;
                o_acc_y = '0;
            end
        end
    end

    always_comb begin
        if (i_ctl.scroll) begin
            o_fx = 8'sd0 - clip8(q_x);
            o_fy = 8'sd0 - clip8(q_y);
        end else begin
            o_fx = 8'sd0 - clip8(i_acc_x);
            o_fy = clip8(i_acc_y);
        end
    end

endmodule

`default_nettype wire

/* tb/tb_trackball_motion_to_report.sv */
// tb_trackball_motion_to_report: self-checking bench for the trackball motion-to-report block,
// with directed and random motion and report words checked against an in-bench predictor.
// Depends on tbm_pkg and the trackball_motion_to_report rtl.
`default_nettype none

module tb_trackball_motion_to_report;
    import tbm_pkg::*;

    // one report word, move_x in the lowest byte
    typedef struct packed {
        logic signed [7:0] scroll_v;
        logic signed [7:0] scroll_h;
        logic signed [7:0] move_y;
        logic signed [7:0] move_x;
    } t_report;

    bit          i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [2:0]  i_cfg_data;

    trackball_motion_to_report i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and configuration
    logic              ball_present;
    logic [2:0]        div_cfg;
    logic signed [15:0] local_x, local_y, remote_x, remote_y;
    t_report           report_q[$];

    int  fail_cnt;
    int  shown_cnt;
    bit  idle_on;
    int  sink_hold;
    t_report want, got;

    function automatic logic signed [15:0] sat_sum(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
        logic signed [16:0] s;
        s = a + b;
        if (s > 17'sd32767) return 16'sh7fff;
        if (s < -17'sd32768) return 16'sh8000;
        return s[15:0];
    endfunction

    function automatic logic signed [7:0] limit_axis(input logic signed [15:0] v);
        if (v > 16'sd127) return 8'sd127;
        if (v < -16'sd127) return -8'sd127;
        return v[7:0];
    endfunction

    // turn one ball's accumulator into report fields
    function automatic void drain_ball(inout logic signed [15:0] ax,
                                       inout logic signed [15:0] ay,
                                       input logic scroll, inout t_report rep);
        logic [2:0]         sh;
        logic signed [15:0] qx, qy;
        logic [15:0]        keep;
        if (scroll) begin
            sh = ((div_cfg == 3'd0) ? 3'd4 : div_cfg) - 3'd1;
            qx = ax >>> sh;
            qy = ay >>> sh;
            keep = (16'd1 << sh) - 16'd1;
            ax = ax & keep;
            ay = ay & keep;
            rep.scroll_h = -limit_axis(qx);
            rep.scroll_v = -limit_axis(qy);
        end else begin
            rep.move_x = -limit_axis(ax);
            rep.move_y = limit_axis(ay);
            ax = '0;
            ay = '0;
        end
    endfunction

    function automatic void predict_word(input t_req req, input logic signed [15:0] dx,
                                         input logic signed [15:0] dy, input logic scroll);
        t_report rep;
        rep = '0;
        case (req)
            REQ_LOCAL: begin
                if (ball_present) begin
                    local_x = sat_sum(local_x, dx);
                    local_y = sat_sum(local_y, dy);
                end
            end
            REQ_REMOTE: begin
                remote_x = sat_sum(remote_x, dx);
                remote_y = sat_sum(remote_y, dy);
            end
            REQ_REPORT: begin
                drain_ball(local_x, local_y, scroll, rep);
                drain_ball(remote_x, remote_y, scroll ^ ball_present, rep);
                report_q.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] e, input logic [7:0] g);
        fail_cnt++;
        if (shown_cnt < 10) begin
            shown_cnt++;
            $display("mismatch %s: expected %0d got %0d", what, $signed(e), $signed(g));
        end
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_report'(o_m_axis_tdata);
            if (report_q.size() == 0) begin
                fail_cnt++;
                if (shown_cnt < 10) begin
                    shown_cnt++;
                    $display("unexpected report word %h", o_m_axis_tdata);
                end
            end else begin
                want = report_q.pop_front();
                if (got.move_x !== want.move_x)
                    note_mismatch("move_x", want.move_x, got.move_x);
                if (got.move_y !== want.move_y)
                    note_mismatch("move_y", want.move_y, got.move_y);
                if (got.scroll_h !== want.scroll_h)
                    note_mismatch("scroll_h", want.scroll_h, got.scroll_h);
                if (got.scroll_v !== want.scroll_v)
                    note_mismatch("scroll_v", want.scroll_v, got.scroll_v);
            end
        end
    end

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 13) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // called just after a falling edge; leaves tvalid high for the next word
    task automatic send_word(input t_req req, input logic signed [15:0] dx,
                             input logic signed [15:0] dy, input logic scroll);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= req;
        i_s_axis_tdata  <= {7'd0, scroll, dy, dx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_word(req, dx, dy, scroll);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every report, then for words still in the pipe
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LOCAL_PRESENT) ball_present = val[0];
        else div_cfg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            2, 3: return 16'($signed($urandom_range(0, 800)) - 400);
            default: return 16'($signed($urandom_range(0, 80)) - 40);
        endcase
    endfunction

    // defaults after reset: local ball absent, divider 4
    task automatic test_reset_defaults();
        send_word(REQ_LOCAL, 16'sd100, -16'sd100, 1'b0);
        send_word(REQ_REMOTE, 16'sd5, -16'sd7, 1'b1);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b0);
        send_word(REQ_UNUSED, 16'sd1234, -16'sd1, 1'b1);
        send_word(REQ_REMOTE, -16'sd20, 16'sd37, 1'b0);
        // deltas on a report word are ignored
        send_word(REQ_REPORT, 16'sh7fff, 16'sh8000, 1'b1);
        send_word(REQ_REPORT, 16'sh8000, 16'sh7fff, 1'b0);
    endtask

    task automatic test_saturation();
        write_reg(CFG_LOCAL_PRESENT, 3'd1);
        write_reg(CFG_DIVIDER, 3'd1);
        send_word(REQ_LOCAL, 16'sh7fff, 16'sh8000, 1'b1);
        send_word(REQ_LOCAL, 16'sh7fff, 16'sh8000, 1'b0);
        send_word(REQ_REMOTE, 16'sh8000, 16'sh7fff, 1'b0);
        send_word(REQ_REMOTE, 16'sh8000, 16'sh7fff, 1'b1);
        send_word(REQ_REMOTE, -16'sd1, 16'sd1, 1'b0);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b0);
        send_word(REQ_LOCAL, 16'sh8000, 16'sh7fff, 1'b0);
        send_word(REQ_LOCAL, -16'sd1, 16'sd1, 1'b0);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_divider_ends();
        write_reg(CFG_LOCAL_PRESENT, 3'd0);
        write_reg(CFG_DIVIDER, 3'd7);
        send_word(REQ_REMOTE, 16'sd200, -16'sd200, 1'b0);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b1);
        // a divider of zero behaves as four
        write_reg(CFG_DIVIDER, 3'd0);
        send_word(REQ_REMOTE, 16'sd9, -16'sd9, 1'b0);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b1);
        send_word(REQ_REPORT, 16'sd0, 16'sd0, 1'b0);
    endtask

    task automatic test_random(input int phases, input int per_phase);
        int   p, n, k;
        t_req req;
        for (p = 0; p < phases; p++) begin
            idle_on = (p != phases - 1) && (p != 2);
            write_reg(CFG_LOCAL_PRESENT, 3'($urandom_range(0, 1)));
            write_reg(CFG_DIVIDER, (p == 0) ? 3'd1 : (p == 1) ? 3'd7
                                            : 3'($urandom_range(0, 7)));
            for (n = 0; n < per_phase; n++) begin
                k = $urandom_range(0, 19);
                req = (k < 7) ? REQ_LOCAL : (k < 14) ? REQ_REMOTE
                    : (k < 19) ? REQ_REPORT : REQ_UNUSED;
                send_word(req, pick_delta(), pick_delta(), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 99) == 0) settle();
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = REQ_LOCAL;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_LOCAL_PRESENT;
        i_cfg_data      = '0;
        fail_cnt        = 0;
        shown_cnt       = 0;
        sink_hold       = 0;
        idle_on         = 1'b1;
        ball_present    = 1'b0;
        div_cfg         = DIV_RESET;
        local_x  = '0;
        local_y  = '0;
        remote_x = '0;
        remote_y = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_saturation();
        test_divider_ends();
        test_random(6, 170);

        idle_on = 1'b0;
        i_s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS trackball_motion_to_report");
        end else begin
            $display("FAIL trackball_motion_to_report");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL trackball_motion_to_report");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/core/tbm_pkg.sv
rtl/core/tbm_ball.sv
rtl/core/trackball_motion_to_report.sv
tb/tb_trackball_motion_to_report.sv
